// ----- rtl/core/ehte_pkg.sv -----
// shared constants, codes and types of the extendible hash table engine
package ehte_pkg;

  localparam int DEPTH_W  = 5;
  localparam int CFG_W    = 4;
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 3;
  localparam int MIX_R    = 47;

  localparam logic [KEY_W-1:0] ALL_ONES  = '1;
  localparam logic [63:0]      MUL_M     = 64'hc6a4a7935bd1e995;
  localparam logic [63:0]      HASH_SEED = 64'd5516;
  localparam logic [63:0]      HALF_MASK = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0]      HASH_INIT = HASH_SEED ^ (MUL_M << 3);

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_RETRY     = 3'd5,
    ST_CAPACITY  = 3'd6
  } status_t;

endpackage

// ----- rtl/core/ehte_ifs.sv -----
// valid/ready channel interfaces for requests and responses
interface ehte_req_if;
  import ehte_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface ehte_rsp_if;
  import ehte_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

// ----- rtl/core/ehte_hash.sv -----
// iterative 64-bit murmur hash on one shared 32x32 multiplier
module ehte_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ehte_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [63:0]               hash
);
  import ehte_pkg::*;

  logic        busy;
  logic [1:0]  mstep;
  logic [1:0]  mph;
  logic [63:0] x;
  logic [63:0] acc;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] acc_next;

  // low 64 bits of x * M from three partial products
  always_comb begin
    unique case (mph)
      2'd0: begin
        op_a = 32'(x & HALF_MASK);
        op_b = 32'(MUL_M & HALF_MASK);
      end
      2'd1: begin
        op_a = 32'(x & HALF_MASK);
        op_b = 32'(MUL_M >> 32);
      end
      default: begin
        op_a = 32'(x >> 32);
        op_b = 32'(MUL_M & HALF_MASK);
      end
    endcase
    prod = 64'(op_a) * 64'(op_b);
    if (mph == 2'd0) begin
      acc_next = prod;
    end else begin
      acc_next = acc + {prod[31:0], 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      mstep <= '0;
      mph   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      x     <= key;
      mstep <= '0;
      mph   <= '0;
    end else if (busy) begin
      acc <= acc_next;
      if (mph == 2'd2) begin
        mph   <= '0;
        mstep <= mstep + 2'd1;
        unique case (mstep)
          2'd0: x <= acc_next ^ (acc_next >> MIX_R);
          2'd1: x <= HASH_INIT ^ acc_next;
          2'd2: x <= acc_next ^ (acc_next >> MIX_R);
          default: begin
            hash <= acc_next ^ (acc_next >> MIX_R);
            done <= 1'b1;
            busy <= 1'b0;
          end
        endcase
      end else begin
        mph <= mph + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/extendible_hash_table_engine.sv -----
// sequence: accept, hashing, directory read, a read and a compare per probed slot
// (up to PROBE_LINES*SLOTS_PER_LINE slots), then a hand-off into the response register
// a split adds local depth lookup, optional directory double, two segment clears, a walk of
// the old segment with a rehash and first-fit scan per live entry, then a directory rewrite
// throughput: one request at a time, set by the shared hash multiplier and the slot memory port
// reset and every depth write run a clearing sweep over max(SEGMENTS*slots, 2^MAX_DEPTH)
// addresses, during which no request is taken
module extendible_hash_table_engine #(
  parameter int MAX_DEPTH         = 8,
  parameter int SEGMENTS          = 64,
  parameter int LINES_PER_SEGMENT = 64,
  parameter int SLOTS_PER_LINE    = 4,
  parameter int PROBE_LINES       = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ehte_pkg::CFG_W-1:0] cfg_wr_data,
  ehte_req_if.sink                   req,
  ehte_rsp_if.source                 rsp
);
  import ehte_pkg::*;

  // geometry
  localparam int SEG_W       = $clog2(SEGMENTS);
  localparam int FREE_W      = $clog2(SEGMENTS + 1);
  localparam int SPS         = LINES_PER_SEGMENT * SLOTS_PER_LINE;
  localparam int OFF_W       = $clog2(SPS);
  localparam int TOTAL       = SEGMENTS * SPS;
  localparam int ADDR_W      = $clog2(TOTAL);
  localparam int DIR_SIZE    = 1 << MAX_DEPTH;
  localparam int DIR_W       = MAX_DEPTH;
  localparam int LINE_BITS   = $clog2(LINES_PER_SEGMENT);
  localparam int PROBE_SLOTS = PROBE_LINES * SLOTS_PER_LINE;
  localparam int PRB_W       = $clog2(PROBE_SLOTS + 1);
  localparam int LOG_SEG     = $clog2(SEGMENTS + 1) - 1;
  localparam int DMAX        = (MAX_DEPTH < LOG_SEG) ? MAX_DEPTH : LOG_SEG;
  localparam int CLR_N       = (TOTAL > DIR_SIZE) ? TOTAL : DIR_SIZE;
  localparam int CLR_W       = $clog2(CLR_N);

  typedef enum logic [22:0] {
    S_INIT    = 23'd1 << 0,
    S_IDLE    = 23'd1 << 1,
    S_HASH    = 23'd1 << 2,
    S_DIR     = 23'd1 << 3,
    S_SEG     = 23'd1 << 4,
    S_PRB_RD  = 23'd1 << 5,
    S_PRB_CMP = 23'd1 << 6,
    S_SP_LD   = 23'd1 << 7,
    S_SP_CHK  = 23'd1 << 8,
    S_DBL_RD  = 23'd1 << 9,
    S_DBL_WR  = 23'd1 << 10,
    S_POP_A   = 23'd1 << 11,
    S_POP_B   = 23'd1 << 12,
    S_POP_C   = 23'd1 << 13,
    S_CLR     = 23'd1 << 14,
    S_MV_RD   = 23'd1 << 15,
    S_MV_CHK  = 23'd1 << 16,
    S_MV_HASH = 23'd1 << 17,
    S_MV_NEXT = 23'd1 << 18,
    S_SC_RD   = 23'd1 << 19,
    S_SC_CMP  = 23'd1 << 20,
    S_DR_A    = 23'd1 << 21,
    S_DR_B    = 23'd1 << 22
  } state_t;

  // done is folded into the response hand-off below
  state_t state;
  logic   res_ready;

  // slot index inside the flat slot memories
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEG_W-1:0] s,
                                                  input logic [OFF_W-1:0] o);
    return ADDR_W'(s) * ADDR_W'(SPS) + ADDR_W'(o);
  endfunction

  // first slot of the start line, top hash bits folded once below the line count
  function automatic logic [OFF_W-1:0] first_slot(input logic [63:0] h);
    logic [LINE_BITS:0] ext;
    logic [LINE_BITS:0] sl;
    ext = {1'b0, h[63 -: LINE_BITS]};
    sl  = (ext >= (LINE_BITS+1)'(LINES_PER_SEGMENT)) ?
          ext - (LINE_BITS+1)'(LINES_PER_SEGMENT) : ext;
    return OFF_W'(sl) * OFF_W'(SLOTS_PER_LINE);
  endfunction

  function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] o);
    return (o == OFF_W'(SPS - 1)) ? '0 : o + OFF_W'(1);
  endfunction

  // control and working registers
  logic [CFG_W-1:0]   init_depth;
  logic [DEPTH_W-1:0] gd;
  logic [FREE_W-1:0]  fc;
  logic [VAL_W-1:0]   empty_val;
  logic [CLR_W-1:0]   clr;
  logic [REQ_W-1:0]   rq;
  logic [KEY_W-1:0]   rkey;
  logic [VAL_W-1:0]   rval;
  logic [DIR_W-1:0]   didx;
  logic [SEG_W-1:0]   seg, sa, sb, tseg;
  logic [OFF_W-1:0]   off, pcnt, soff, scnt;
  logic [PRB_W-1:0]   prb_cnt;
  logic [DEPTH_W-1:0] sd;
  logic [DIR_W:0]     dcnt;
  logic               second;
  logic [KEY_W-1:0]   mkey;
  logic [VAL_W-1:0]   mval;
  status_t            res_status;
  logic [VAL_W-1:0]   res_found;
  logic               out_valid;
  status_t            out_status;
  logic [VAL_W-1:0]   out_found;
  logic               in_done;

  // memories
  logic [KEY_W-1:0]   key_mem [TOTAL];
  logic [VAL_W-1:0]   val_mem [TOTAL];
  logic [SEG_W-1:0]   dir_mem [DIR_SIZE];
  logic [DEPTH_W-1:0] ld_mem  [SEGMENTS];
  logic [SEG_W-1:0]   stk_mem [SEGMENTS];

  logic               key_we, val_we, dir_we, ld_we, stk_we;
  logic [ADDR_W-1:0]  slot_raddr, key_waddr, val_waddr;
  logic [KEY_W-1:0]   key_wdata, key_rd;
  logic [VAL_W-1:0]   val_wdata, val_rd;
  logic [DIR_W-1:0]   dir_raddr, dir_waddr;
  logic [SEG_W-1:0]   dir_wdata, dir_rd;
  logic [SEG_W-1:0]   ld_waddr;
  logic [DEPTH_W-1:0] ld_wdata, ld_rd;
  logic [SEG_W-1:0]   stk_raddr, stk_waddr, stk_wdata, stk_rd;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd <= key_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rd <= val_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rd <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      ld_mem[ld_waddr] <= ld_wdata;
    end
    ld_rd <= ld_mem[seg];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd <= stk_mem[stk_raddr];
  end

  // hash unit
  logic        hash_start, hash_done;
  logic [63:0] hash_out, hash_sh;
  logic [KEY_W-1:0] hash_key;

  ehte_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .hash  (hash_out)
  );

  // derived values
  logic               accept;
  logic [DEPTH_W-1:0] init_d;
  logic [DIR_W:0]     init_n, gd_n;
  logic [DIR_W-1:0]   didx_c, low;
  logic [DIR_W+1:0]   half, step, dsum;
  logic               prb_empty, prb_hit, mv_live, sc_empty;
  logic [SEG_W-1:0]   cseg;

  // no new beat while the previous result still waits for the output register
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !in_done;
  assign init_d    = ({1'b0, init_depth} > DEPTH_W'(DMAX)) ? DEPTH_W'(DMAX)
                                                           : {1'b0, init_depth};
  assign init_n    = (DIR_W+1)'(1) << init_d;
  assign gd_n      = (DIR_W+1)'(1) << gd;
  assign didx_c    = DIR_W'(hash_out) & DIR_W'(gd_n - (DIR_W+1)'(1));
  assign low       = didx & DIR_W'(((DIR_W+1)'(1) << sd) - (DIR_W+1)'(1));
  assign half      = (DIR_W+2)'(1) << sd;
  assign step      = half << 1;
  assign dsum      = (DIR_W+2)'(dcnt) + step;
  assign hash_sh   = hash_out >> sd;
  assign prb_empty = (rq == REQ_INSERT) && (key_rd == ALL_ONES);
  assign prb_hit   = (key_rd == rkey);
  assign mv_live   = (key_rd != ALL_ONES) && (val_rd != '0);
  assign sc_empty  = (key_rd == ALL_ONES);
  assign cseg      = second ? sb : sa;

  assign hash_key   = (state == S_IDLE) ? req.key : key_rd;
  assign hash_start = (accept && req.req_type != REQ_NOP && req.key != ALL_ONES) ||
                      (state == S_MV_CHK && mv_live);

  // memory port steering
  always_comb begin
    key_we = 1'b0;  key_waddr = slot_addr(seg, off);  key_wdata = ALL_ONES;
    val_we = 1'b0;  val_waddr = slot_addr(seg, off);  val_wdata = rval;
    dir_we = 1'b0;  dir_waddr = DIR_W'(clr);          dir_wdata = '0;
    ld_we  = 1'b0;  ld_waddr  = SEG_W'(clr);          ld_wdata  = init_d;
    stk_we = 1'b0;  stk_waddr = SEG_W'(clr);
    stk_wdata = SEG_W'(SEGMENTS - 1) - SEG_W'(clr);
    dir_raddr  = didx_c;
    stk_raddr  = SEG_W'(fc - FREE_W'(1));
    slot_raddr = slot_addr(seg, off);
    unique case (state)
      S_INIT: begin
        // clearing sweep over the key, directory, depth and free-stack stores at once
        key_we    = (32'(clr) < 32'(TOTAL));
        key_waddr = ADDR_W'(clr);
        dir_we    = (32'(clr) < 32'(DIR_SIZE));
        dir_wdata = (32'(clr) < 32'(init_n)) ? SEG_W'(clr) : '0;
        ld_we     = (32'(clr) < 32'(SEGMENTS));
        stk_we    = (32'(clr) < 32'(SEGMENTS));
      end
      S_PRB_CMP: begin
        key_we    = prb_empty;
        key_wdata = rkey;
        val_we    = prb_empty || (prb_hit && (rq == REQ_INSERT || rq == REQ_REMOVE));
        val_wdata = (prb_hit && rq == REQ_REMOVE) ? '0 : rval;
      end
      S_DBL_RD: dir_raddr = DIR_W'(dcnt);
      S_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = DIR_W'(dcnt + gd_n);
        dir_wdata = dir_rd;
      end
      S_POP_B: stk_raddr = SEG_W'(fc - FREE_W'(2));
      S_CLR: begin
        key_we    = 1'b1;
        key_waddr = slot_addr(cseg, off);
        ld_we     = (off == '0);
        ld_waddr  = cseg;
        ld_wdata  = sd + DEPTH_W'(1);
      end
      S_MV_RD: slot_raddr = slot_addr(seg, pcnt);
      S_SC_RD: slot_raddr = slot_addr(tseg, soff);
      S_SC_CMP: begin
        key_we    = sc_empty;
        key_waddr = slot_addr(tseg, soff);
        key_wdata = mkey;
        val_we    = sc_empty;
        val_waddr = slot_addr(tseg, soff);
        val_wdata = mval;
      end
      S_DR_A: begin
        dir_we    = 1'b1;
        dir_waddr = DIR_W'(dcnt);
        dir_wdata = sa;
      end
      S_DR_B: begin
        dir_we    = 1'b1;
        dir_waddr = DIR_W'(dcnt);
        dir_wdata = sb;
        // last pass also returns the old segment to the free stack
        if (dsum >= (DIR_W+2)'(gd_n)) begin
          stk_we    = 1'b1;
          stk_waddr = SEG_W'(fc);
          stk_wdata = seg;
        end
      end
      default: begin
      end
    endcase
  end

  // response register: a finished result waits here while the sequencer goes on
  assign res_ready     = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_done && res_ready) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_found  <= res_found;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_depth <= CFG_RESET;
      clr        <= '0;
      gd         <= '0;
      fc         <= '0;
      in_done    <= 1'b0;
    end else if (cfg_wr_en) begin
      // new depth: rebuild the whole table
      init_depth <= cfg_wr_data;
      state      <= S_INIT;
      clr        <= '0;
      in_done    <= 1'b0;
    end else begin
      if (in_done && res_ready) begin
        in_done <= 1'b0;
        state   <= S_IDLE;
      end
      unique case (state)
        S_INIT: begin
          gd        <= init_d;
          fc        <= FREE_W'(SEGMENTS) - FREE_W'(init_n);
          empty_val <= '0;
          clr       <= clr + CLR_W'(1);
          if (clr == CLR_W'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && !in_done) begin
            rq         <= req.req_type;
            rkey       <= req.key;
            rval       <= req.value;
            res_status <= ST_NOT_FOUND;
            res_found  <= '0;
            if (req.req_type == REQ_NOP) begin
              in_done <= 1'b1;
            end else if (req.key == ALL_ONES) begin
              // reserved key lives in its own register
              in_done <= 1'b1;
              unique case (req.req_type)
                REQ_FIND: begin
                  if (empty_val != '0) begin
                    res_status <= ST_FOUND;
                    res_found  <= empty_val;
                  end
                end
                REQ_INSERT: begin
                  res_status <= (empty_val != '0) ? ST_UPDATED : ST_INSERTED;
                  empty_val  <= req.value;
                end
                default: begin
                  empty_val  <= '0;
                  res_status <= ST_REMOVED;
                end
              endcase
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_DIR;
          end
        end
        S_DIR: begin
          didx  <= didx_c;
          state <= S_SEG;
        end
        S_SEG: begin
          seg     <= dir_rd;
          off     <= first_slot(hash_out);
          prb_cnt <= '0;
          state   <= S_PRB_RD;
        end
        S_PRB_RD: state <= S_PRB_CMP;
        S_PRB_CMP: begin
          if (prb_empty) begin
            res_status <= ST_INSERTED;
            in_done    <= 1'b1;
            state      <= S_IDLE;
          end else if (prb_hit) begin
            in_done <= 1'b1;
            state   <= S_IDLE;
            unique case (rq)
              REQ_FIND: begin
                if (val_rd != '0) begin
                  res_status <= ST_FOUND;
                  res_found  <= val_rd;
                end
              end
              REQ_INSERT: res_status <= ST_UPDATED;
              default:    res_status <= ST_REMOVED;
            endcase
          end else if (prb_cnt == PRB_W'(PROBE_SLOTS - 1)) begin
            if (rq == REQ_INSERT) begin
              state <= S_SP_LD;
            end else begin
              in_done <= 1'b1;
              state   <= S_IDLE;
            end
          end else begin
            off     <= off_inc(off);
            prb_cnt <= prb_cnt + PRB_W'(1);
            state   <= S_PRB_RD;
          end
        end
        S_SP_LD: state <= S_SP_CHK;
        S_SP_CHK: begin
          // no room: directory at its limit or fewer than two free segments
          if ((ld_rd >= gd && gd >= DEPTH_W'(MAX_DEPTH)) || fc < FREE_W'(2)) begin
            res_status <= ST_CAPACITY;
            in_done    <= 1'b1;
            state      <= S_IDLE;
          end else if (ld_rd >= gd) begin
            sd    <= gd;
            dcnt  <= '0;
            state <= S_DBL_RD;
          end else begin
            sd    <= ld_rd;
            state <= S_POP_A;
          end
        end
        S_DBL_RD: state <= S_DBL_WR;
        S_DBL_WR: begin
          if (dcnt == gd_n - (DIR_W+1)'(1)) begin
            gd    <= gd + DEPTH_W'(1);
            state <= S_POP_A;
          end else begin
            dcnt  <= dcnt + (DIR_W+1)'(1);
            state <= S_DBL_RD;
          end
        end
        S_POP_A: state <= S_POP_B;
        S_POP_B: begin
          sa    <= stk_rd;
          state <= S_POP_C;
        end
        S_POP_C: begin
          sb     <= stk_rd;
          fc     <= fc - FREE_W'(2);
          off    <= '0;
          second <= 1'b0;
          state  <= S_CLR;
        end
        S_CLR: begin
          off <= off_inc(off);
          if (off == OFF_W'(SPS - 1)) begin
            if (second) begin
              pcnt  <= '0;
              state <= S_MV_RD;
            end else begin
              second <= 1'b1;
            end
          end
        end
        S_MV_RD: state <= S_MV_CHK;
        S_MV_CHK: begin
          // removed and empty slots are dropped by the split
          if (mv_live) begin
            mkey  <= key_rd;
            mval  <= val_rd;
            state <= S_MV_HASH;
          end else begin
            state <= S_MV_NEXT;
          end
        end
        S_MV_HASH: begin
          if (hash_done) begin
            tseg  <= hash_sh[0] ? sb : sa;
            soff  <= first_slot(hash_out);
            scnt  <= '0;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          if (sc_empty || scnt == OFF_W'(SPS - 1)) begin
            state <= S_MV_NEXT;
          end else begin
            soff  <= off_inc(soff);
            scnt  <= scnt + OFF_W'(1);
            state <= S_SC_RD;
          end
        end
        S_MV_NEXT: begin
          if (pcnt == OFF_W'(SPS - 1)) begin
            dcnt  <= (DIR_W+1)'(low);
            state <= S_DR_A;
          end else begin
            pcnt  <= pcnt + OFF_W'(1);
            state <= S_MV_RD;
          end
        end
        S_DR_A: begin
          // directory entries with the new bit clear go to the first new segment
          if (dsum >= (DIR_W+2)'(gd_n)) begin
            dcnt  <= (DIR_W+1)'(low) + (DIR_W+1)'(half);
            state <= S_DR_B;
          end else begin
            dcnt <= (DIR_W+1)'(dsum);
          end
        end
        S_DR_B: begin
          if (dsum >= (DIR_W+2)'(gd_n)) begin
            fc         <= fc + FREE_W'(1);
            res_status <= ST_RETRY;
            in_done    <= 1'b1;
            state      <= S_IDLE;
          end else begin
            dcnt <= (DIR_W+1)'(dsum);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= FREE_W'(SEGMENTS))
    else $error("free segment count above segment total");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    gd <= DEPTH_W'(MAX_DEPTH))
    else $error("global depth above limit");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_done))
    else $error("response beat without a finished request");

  a_hash_owner: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH || state == S_MV_HASH))
    else $error("hash result while no step waits for it");
`endif

endmodule

// ----- test/ehte_checker.sv -----
// checker for the hash table engine: table predictor and response scoreboard
`timescale 1ns / 100ps

module ehte_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  ehte_req_if        req,
  ehte_rsp_if        rsp,
  output int         fail_count,
  output int         pending_count
);
  import ehte_pkg::*;

  localparam int MAX_DEPTH = 8;
  localparam int SEGS      = 64;
  localparam int SEG_SLOTS = 256;
  localparam int LINE_SLOTS = 4;
  localparam int WINDOW    = 16;

  typedef struct packed {
    status_t     st;
    logic [63:0] val;
  } answer_t;

  answer_t     answers[$];
  int          gdepth;
  logic [5:0]  dir_seg[256];
  int          seg_depth[SEGS];
  logic [63:0] tkey[SEGS*SEG_SLOTS];
  logic [63:0] tval[SEGS*SEG_SLOTS];
  int          spare[$];
  logic [63:0] reserved_val;

  function automatic logic [63:0] murmur(input logic [63:0] key);
    logic [63:0] h;
    logic [63:0] k;
    h = HASH_INIT;
    k = key * MUL_M;
    k = k ^ (k >> MIX_R);
    k = k * MUL_M;
    h = (h ^ k) * MUL_M;
    h = h ^ (h >> MIX_R);
    h = h * MUL_M;
    h = h ^ (h >> MIX_R);
    return h;
  endfunction

  function automatic void rebuild(input logic [3:0] depth_req);
    int d;
    d = depth_req;
    while (d > 0 && (d > MAX_DEPTH || (1 << d) > SEGS)) d--;
    gdepth = d;
    foreach (dir_seg[i]) dir_seg[i] = (i < (1 << d)) ? i[5:0] : '0;
    foreach (tkey[i]) begin
      tkey[i] = ALL_ONES;
      tval[i] = '0;
    end
    foreach (seg_depth[i]) seg_depth[i] = d;
    spare.delete();
    // stack: lowest free segment sits on top (back of queue)
    for (int i = SEGS - 1; i >= (1 << d); i--) spare.push_back(i);
    reserved_val = '0;
  endfunction

  function automatic status_t split(input int dir_idx);
    int seg, d, a, b, n, step, low, first, pos;
    logic [63:0] h;
    seg = dir_seg[dir_idx];
    d = seg_depth[seg];
    if (d >= gdepth && gdepth >= MAX_DEPTH) return ST_CAPACITY;
    if (spare.size() < 2) return ST_CAPACITY;
    if (d >= gdepth) begin
      n = 1 << gdepth;
      for (int i = 0; i < n; i++) dir_seg[i + n] = dir_seg[i];
      gdepth++;
      d = gdepth - 1;
    end
    a = spare.pop_back();
    b = spare.pop_back();
    for (int i = 0; i < SEG_SLOTS; i++) begin
      tkey[a*SEG_SLOTS + i] = ALL_ONES;
      tkey[b*SEG_SLOTS + i] = ALL_ONES;
    end
    seg_depth[a] = d + 1;
    seg_depth[b] = d + 1;
    // live entries move, removed ones (zero value) are dropped
    for (int p = 0; p < SEG_SLOTS; p++) begin
      if (tkey[seg*SEG_SLOTS + p] != ALL_ONES && tval[seg*SEG_SLOTS + p] != 0) begin
        h = murmur(tkey[seg*SEG_SLOTS + p]);
        first = h[63:58] * LINE_SLOTS;
        for (int q = 0; q < SEG_SLOTS; q++) begin
          pos = (h[d] ? b : a) * SEG_SLOTS + (first + q) % SEG_SLOTS;
          if (tkey[pos] == ALL_ONES) begin
            tkey[pos] = tkey[seg*SEG_SLOTS + p];
            tval[pos] = tval[seg*SEG_SLOTS + p];
            break;
          end
        end
      end
    end
    n = 1 << gdepth;
    step = 1 << (d + 1);
    low = dir_idx & ((1 << d) - 1);
    for (int i = low; i < n; i += step) dir_seg[i] = a[5:0];
    for (int i = low + (1 << d); i < n; i += step) dir_seg[i] = b[5:0];
    spare.push_back(seg);
    return ST_RETRY;
  endfunction

  function automatic answer_t lookup(input logic [1:0] op, input logic [63:0] key,
                                     input logic [63:0] value);
    answer_t     r;
    logic [63:0] h;
    int          dir_idx, base, first, pos;
    bit          done;
    r.st = ST_NOT_FOUND;
    r.val = '0;
    done = 0;
    if (op != REQ_FIND && op != REQ_INSERT && op != REQ_REMOVE) return r;
    if (key == ALL_ONES) begin
      if (op == REQ_FIND) begin
        if (reserved_val != 0) begin
          r.st = ST_FOUND;
          r.val = reserved_val;
        end
      end else if (op == REQ_INSERT) begin
        r.st = (reserved_val != 0) ? ST_UPDATED : ST_INSERTED;
        reserved_val = value;
      end else begin
        reserved_val = '0;
        r.st = ST_REMOVED;
      end
      return r;
    end
    h = murmur(key);
    dir_idx = h & ((64'd1 << gdepth) - 1);
    base = dir_seg[dir_idx] * SEG_SLOTS;
    first = h[63:58] * LINE_SLOTS;
    for (int i = 0; i < WINDOW && !done; i++) begin
      pos = base + (first + i) % SEG_SLOTS;
      if (op == REQ_INSERT && tkey[pos] == ALL_ONES) begin
        tkey[pos] = key;
        tval[pos] = value;
        r.st = ST_INSERTED;
        done = 1;
      end else if (tkey[pos] == key) begin
        if (op == REQ_FIND) begin
          if (tval[pos] != 0) begin
            r.st = ST_FOUND;
            r.val = tval[pos];
          end
        end else if (op == REQ_INSERT) begin
          tval[pos] = value;
          r.st = ST_UPDATED;
        end else begin
          tval[pos] = '0;
          r.st = ST_REMOVED;
        end
        done = 1;
      end
    end
    if (!done && op == REQ_INSERT) r.st = split(dir_idx);
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rebuild(CFG_RESET);
      answers.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) rebuild(cfg_wr_data);
      if (req.valid && req.ready) answers.push_back(lookup(req.req_type, req.key, req.value));
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          if (fail_count < 10) $display("unexpected response beat: status %0d value %h",
                                        rsp.status, rsp.found_value);
          fail_count <= fail_count + 1;
        end else begin
          want = answers.pop_front();
          if (rsp.status !== want.st || rsp.found_value !== want.val) begin
            if (fail_count < 10)
              $display("mismatch: expected %s/%h got %0d/%h", want.st.name(), want.val,
                       rsp.status, rsp.found_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= answers.size();
  end

endmodule

// ----- test/extendible_hash_table_engine_tb.sv -----
// top of the hash table engine testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module extendible_hash_table_engine_tb;
  import ehte_pkg::*;

  // request code the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_BOGUS = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;
  int         fail_count;
  int         pending_count;

  ehte_req_if req_if ();
  ehte_rsp_if rsp_if ();

  extendible_hash_table_engine uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  ehte_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req           (req_if),
    .rsp           (rsp_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // generous ceiling: clearing sweeps plus worst case split walks
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // response side stalls in one of four modes, picked at random
  int rsp_cycle;
  int rsp_mode;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rsp_cycle <= 0;
      rsp_mode <= 0;
    end else begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % 64 == 0) rsp_mode <= $urandom_range(0, 3);
      case (rsp_mode)
        0: rsp_if.ready <= 1'b1;                               // no stalls
        1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
        2: rsp_if.ready <= (rsp_cycle % 5 != 0);              // regular hiccup
        default: rsp_if.ready <= ($urandom_range(0, 9) < 2);  // heavy back-pressure
      endcase
    end
  end

  int          burst_left;
  int          items_sent;
  int          depth_phases;
  logic [63:0] key_pool[$];

  // one request beat, sent in bursts with random gaps in between
  task automatic send_req(input logic [1:0] op, input logic [63:0] key,
                          input logic [63:0] value);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.key      <= key;
    req_if.value    <= value;
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // register write only once the table has gone quiet
  task automatic set_depth(input logic [3:0] depth);
    drain();
    repeat (20) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= depth;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    key_pool.delete();
    depth_phases++;
  endtask

  // a fresh key whose hash has zero low bits under mask and start line zero,
  // so a run of them piles into one probe window
  function automatic logic [63:0] colliding_key(input logic [63:0] mask);
    logic [63:0] k;
    logic [63:0] h;
    do begin
      k = {$urandom(), $urandom()};
      h = chk.murmur(k);
    end while ((h & mask) != 0 || h[63:58] != 0 || k == ALL_ONES);
    return k;
  endfunction

  task automatic random_reqs(input int n, input int insert_pct);
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] value;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) op = REQ_INSERT;
      else if (r < insert_pct + (100 - insert_pct) / 2) op = REQ_FIND;
      else op = REQ_REMOVE;
      if ($urandom_range(0, 49) == 0) op = REQ_BOGUS;
      if ($urandom_range(0, 39) == 0) key = ALL_ONES;
      else if (key_pool.size() != 0 && $urandom_range(0, 1))
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key = {$urandom(), $urandom()};
      value = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom(), $urandom()};
      if (op == REQ_INSERT && key != ALL_ONES) begin
        if (key_pool.size() < 64) key_pool.push_back(key);
        else key_pool[$urandom_range(0, 63)] = key;
      end
      send_req(op, key, value);
    end
  endtask

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_FIND;
    req_if.key   = '0;
    req_if.value = '0;
    burst_left   = 0;
    items_sent   = 0;
    depth_phases = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: each operation, removed entries, the reserved key, odd request
    ka = 64'h0123_4567_89ab_cdef;
    kb = 64'h0;
    send_req(REQ_FIND,   ka, 64'hdead);
    send_req(REQ_INSERT, ka, ALL_ONES);
    send_req(REQ_FIND,   ka, 64'h0);
    send_req(REQ_INSERT, ka, 64'h1);
    send_req(REQ_FIND,   ka, 64'h0);
    send_req(REQ_REMOVE, ka, 64'h0);
    send_req(REQ_FIND,   ka, 64'h0);
    send_req(REQ_INSERT, ka, 64'h0);   // update of a removed entry, still zero
    send_req(REQ_FIND,   ka, 64'h0);
    send_req(REQ_REMOVE, kb, 64'h0);   // absent key
    send_req(REQ_INSERT, kb, 64'h8000_0000_0000_0000);
    send_req(REQ_FIND,   kb, 64'h0);
    send_req(REQ_FIND,   ALL_ONES, 64'h0);
    send_req(REQ_INSERT, ALL_ONES, 64'h55);
    send_req(REQ_INSERT, ALL_ONES, ALL_ONES);
    send_req(REQ_FIND,   ALL_ONES, 64'h0);
    send_req(REQ_REMOVE, ALL_ONES, 64'h0);
    send_req(REQ_FIND,   ALL_ONES, 64'h0);
    send_req(REQ_BOGUS,  ka, ALL_ONES);
    send_req(REQ_FIND,   ALL_ONES - 1, 64'h0);

    // depth zero: one segment, a packed window forces a split
    set_depth(4'd0);
    for (int i = 0; i < 17; i++) send_req(REQ_INSERT, colliding_key(64'h0), $urandom() | 1);
    random_reqs(330, 70);

    // oversize depth clamps to all segments in use: a full window cannot split
    set_depth(4'd15);
    for (int i = 0; i < 17; i++) send_req(REQ_INSERT, colliding_key(64'h3f), $urandom() | 1);
    random_reqs(120, 50);

    set_depth(4'd8);
    random_reqs(100, 50);

    // medium depth with a full pause partway through
    set_depth(4'd3);
    random_reqs(120, 65);
    drain();
    random_reqs(130, 65);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d requests over %0d depth settings, forced split and full table",
             items_sent, depth_phases);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
